// File: hw/rtl/ensc_pkg.sv
// Shared types, constants and helpers for the environmental sensor compensation block.
package ensc_pkg;

  typedef struct packed {
    logic [19:0] press_raw;
    logic [19:0] temp_raw;
    logic [15:0] hum_raw;
  } ensc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic signed [31:0] pressure;
    logic        [16:0] humidity;
    logic               div_fault;
  } ensc_out_t;

  typedef struct packed {
    logic [39:0] temp_cal;
    logic [55:0] press_cal_a;
    logic [63:0] press_cal_b;
    logic [7:0]  press_cal_c;
    logic [63:0] hum_cal;
  } ensc_cal_t;

  // front end to divider: humidity and temperature done, pressure operands as magnitudes
  typedef struct packed {
    logic [15:0] temperature;
    logic [16:0] humidity;
    logic        div_fault;
    logic        post2;
    logic        qneg;
    logic [31:0] nmag;
    logic [31:0] dmag;
  } ensc_fwd_t;

  typedef struct packed {
    logic [15:0] temperature;
    logic [16:0] humidity;
    logic        div_fault;
    logic        post2;
    logic        qneg;
    logic [31:0] quo;
  } ensc_quo_t;

  typedef enum logic [2:0] {
    REG_TEMP_CAL,
    REG_PRESS_CAL_A,
    REG_PRESS_CAL_B,
    REG_PRESS_CAL_C,
    REG_HUM_CAL
  } ensc_reg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [31:0] PRESS_T_OFFSET  = 32'sd64000;
  localparam logic signed [31:0] PRESS_FULL      = 32'sd1048576;
  localparam logic signed [31:0] PRESS_SCALE     = 32'sd3125;
  localparam logic signed [31:0] PRESS_OVF_CHECK = 32'sh40000000;
  localparam logic signed [31:0] PRESS_P1_BIAS   = 32'sd32768;
  localparam logic signed [31:0] HUM_MAX         = 32'sd100000;
  localparam logic signed [31:0] HUM_SCALE       = 32'sd1000;
  localparam logic signed [31:0] HUM_BIAS        = 32'sd16384;
  localparam logic signed [31:0] TEMP_MUL        = 32'sd5;
  localparam logic signed [31:0] TEMP_ROUND      = 32'sd128;
  localparam logic [63:0]        RECIP_100       = 64'd1374389535;

  // signed divide by 100, truncating toward zero
  function automatic logic signed [31:0] div100(input logic signed [31:0] x);
    logic [31:0] mag;
    logic [63:0] prod;
    logic [31:0] q;
    mag  = x[31] ? (~x + 32'd1) : x;
    prod = {32'd0, mag} * RECIP_100;
    q    = {5'd0, prod[63:37]};
    return x[31] ? $signed(~q + 32'd1) : $signed(q);
  endfunction

endpackage

// File: hw/rtl/ensc_front.sv
// Front pipeline: temperature, humidity and pressure ahead of the divider.
module ensc_front (
  input  logic              clk,
  input  logic              rst,
  input  ensc_pkg::ensc_cal_t cal,
  input  logic              in_valid,
  output logic              in_ready,
  input  ensc_pkg::ensc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ensc_pkg::ensc_fwd_t out_item
);
  import ensc_pkg::*;

  localparam int N = 14;

  typedef struct packed {
    logic [19:0]        press_raw;
    logic [15:0]        hum_raw;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
    logic signed [31:0] csq;
    logic signed [31:0] cc;
    logic signed [31:0] tf;
    logic signed [31:0] ts;
    logic signed [31:0] v1;
    logic signed [31:0] q;
    logic signed [31:0] qq;
    logic signed [31:0] v1p5;
    logic signed [31:0] p2v1;
    logic signed [31:0] m3;
    logic signed [31:0] m4;
    logic signed [31:0] m5;
    logic signed [31:0] m7;
    logic signed [31:0] v2a;
    logic signed [31:0] v2b;
    logic signed [31:0] v1a;
    logic signed [31:0] p2h;
    logic signed [31:0] d3;
    logic signed [31:0] d4;
    logic signed [31:0] d5;
    logic signed [31:0] d7;
    logic signed [31:0] v2;
    logic signed [31:0] v1s;
    logic signed [31:0] hv1;
    logic signed [31:0] m55;
    logic signed [31:0] dvs;
    logic signed [31:0] pc0;
    logic signed [31:0] hb;
    logic signed [31:0] hv4;
    logic signed [31:0] hv2;
    logic signed [31:0] num;
    logic               post2;
    logic               fault;
    logic signed [31:0] hv3;
    logic signed [31:0] hv5;
    logic signed [31:0] hv6;
    logic [16:0]        hum;
    logic               qneg;
    logic [31:0]        nmag;
    logic [31:0]        dmag;
  } fe_t;

  logic signed [31:0] t1, t2, t3x16, p1, p2, p3x32, p4x65536, p5, p6;
  logic signed [31:0] h1x16, h2, h3, h4, h5, h6x128, h7;

  assign t1       = {16'd0, cal.temp_cal[15:0]};
  assign t2       = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
  assign t3x16    = {{20{cal.temp_cal[39]}}, cal.temp_cal[39:32], 4'd0};
  assign p1       = {16'd0, cal.press_cal_a[15:0]};
  assign p2       = {{16{cal.press_cal_a[31]}}, cal.press_cal_a[31:16]};
  assign p3x32    = {{19{cal.press_cal_a[39]}}, cal.press_cal_a[39:32], 5'd0};
  assign p4x65536 = {cal.press_cal_a[55:40], 16'd0};
  assign p5       = {{16{cal.press_cal_b[15]}}, cal.press_cal_b[15:0]};
  assign p6       = {{24{cal.press_cal_b[23]}}, cal.press_cal_b[23:16]};
  assign h1x16    = {16'd0, cal.hum_cal[11:0], 4'd0};
  assign h2       = {20'd0, cal.hum_cal[23:12]};
  assign h3       = {{24{cal.hum_cal[31]}}, cal.hum_cal[31:24]};
  assign h4       = {{24{cal.hum_cal[39]}}, cal.hum_cal[39:32]};
  assign h5       = {{24{cal.hum_cal[47]}}, cal.hum_cal[47:40]};
  assign h6x128   = {17'd0, cal.hum_cal[55:48], 7'd0};
  assign h7       = {{24{cal.hum_cal[63]}}, cal.hum_cal[63:56]};

  fe_t        st [N];
  fe_t        nx [N];
  logic [N-1:0] v;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !v[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    logic signed [34:0] pa;
    logic signed [31:0] tc0;
    logic signed [35:0] psq;
    logic signed [35:0] pcc;
    logic signed [31:0] tt;
    logic signed [31:0] e;
    logic signed [31:0] he;
    nx[0] = '0;
    for (int k = 1; k < N; k++) begin
      nx[k] = st[k-1];
    end
    // stage 0
    nx[0].press_raw = in_item.press_raw;
    nx[0].hum_raw   = in_item.hum_raw;
    nx[0].ta        = {15'd0, in_item.temp_raw[19:3]} - {15'd0, t1[15:0], 1'b0};
    // stage 1
    pa            = 35'(st[0].ta) * 35'(t2);
    nx[1].tb      = 32'(pa >>> 11);
    tc0           = st[0].ta >>> 1;
    psq           = 36'(tc0) * 36'(tc0);
    nx[1].csq     = 32'(psq >>> 12);
    // stage 2
    pcc           = 36'(st[1].csq) * 36'(t3x16);
    nx[2].cc      = 32'(pcc >>> 14);
    // stage 3
    nx[3].tf      = st[2].tb + st[2].cc;
    // stage 4
    tt            = st[3].tf * TEMP_MUL + TEMP_ROUND;
    nx[4].ts      = tt >>> 8;
    nx[4].v1      = (st[3].tf >>> 1) - PRESS_T_OFFSET;
    nx[4].q       = ((st[3].tf >>> 1) - PRESS_T_OFFSET) >>> 2;
    // stage 5
    nx[5].qq      = st[4].q * st[4].q;
    nx[5].v1p5    = st[4].v1 * p5;
    nx[5].p2v1    = p2 * st[4].v1;
    nx[5].m3      = st[4].ts * h3;
    nx[5].m4      = st[4].ts * h4;
    nx[5].m5      = st[4].ts * h5;
    nx[5].m7      = st[4].ts * h7;
    // stage 6
    nx[6].v2a     = ((st[5].qq >>> 11) * p6) >>> 2;
    nx[6].v2b     = st[5].v1p5 <<< 1;
    nx[6].v1a     = ((st[5].qq >>> 13) * p3x32) >>> 3;
    nx[6].p2h     = st[5].p2v1 >>> 1;
    nx[6].d3      = div100(st[5].m3);
    nx[6].d4      = div100(st[5].m4);
    nx[6].d5      = div100(st[5].m5);
    nx[6].d7      = div100(st[5].m7);
    // stage 7
    nx[7].v2      = ((st[6].v2a + st[6].v2b) >>> 2) + p4x65536;
    nx[7].v1s     = (st[6].v1a + st[6].p2h) >>> 18;
    nx[7].hv1     = ($signed({16'd0, st[6].hum_raw}) - h1x16) - (st[6].d3 >>> 1);
    nx[7].m55     = st[6].ts * st[6].d5;
    // stage 8
    nx[8].dvs     = ((PRESS_P1_BIAS + st[7].v1s) * p1) >>> 15;
    nx[8].pc0     = (PRESS_FULL - $signed({12'd0, st[7].press_raw}) - (st[7].v2 >>> 12))
                    * PRESS_SCALE;
    nx[8].hb      = div100(st[7].m55 >>> 6);
    nx[8].hv4     = (h6x128 + st[7].d7) >>> 4;
    // stage 9
    nx[9].hv2     = (h2 * (st[8].d4 + st[8].hb + HUM_BIAS)) >>> 10;
    nx[9].post2   = st[8].pc0 >= PRESS_OVF_CHECK;
    nx[9].num     = (st[8].pc0 >= PRESS_OVF_CHECK) ? st[8].pc0 : (st[8].pc0 <<< 1);
    nx[9].fault   = st[8].dvs == 32'sd0;
    // stage 10
    nx[10].hv3    = st[9].hv1 * st[9].hv2;
    nx[10].nmag   = st[9].num[31] ? (~st[9].num + 32'd1) : st[9].num;
    nx[10].dmag   = st[9].dvs[31] ? (~st[9].dvs + 32'd1) : st[9].dvs;
    nx[10].qneg   = st[9].num[31] ^ st[9].dvs[31];
    // stage 11
    e             = st[10].hv3 >>> 14;
    nx[11].hv5    = (e * e) >>> 10;
    // stage 12
    nx[12].hv6    = (st[11].hv4 * st[11].hv5) >>> 1;
    // stage 13
    he            = (((st[12].hv3 + st[12].hv6) >>> 10) * HUM_SCALE) >>> 12;
    if (he > HUM_MAX) begin
      nx[13].hum = HUM_MAX[16:0];
    end else if (he < 32'sd0) begin
      nx[13].hum = '0;
    end else begin
      nx[13].hum = he[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  assign out_valid             = v[N-1];
  assign out_item.temperature  = st[N-1].ts[15:0];
  assign out_item.humidity     = st[N-1].hum;
  assign out_item.div_fault    = st[N-1].fault;
  assign out_item.post2        = st[N-1].post2;
  assign out_item.qneg         = st[N-1].qneg;
  assign out_item.nmag         = st[N-1].nmag;
  assign out_item.dmag         = st[N-1].dmag;

endmodule

// File: hw/rtl/ensc_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the pressure divide.
module ensc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ensc_pkg::ensc_fwd_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ensc_pkg::ensc_quo_t out_item
);
  import ensc_pkg::*;

  localparam int N = 32;

  typedef struct packed {
    ensc_fwd_t   f;
    logic [31:0] rem;
  } dv_t;

  dv_t          st [N];
  dv_t          nx [N];
  logic [N-1:0] v;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !v[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    dv_t         cur;
    logic [32:0] rr;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        cur.f   = in_item;
        cur.rem = '0;
      end else begin
        cur = st[k-1];
      end
      rr          = {cur.rem, cur.f.nmag[31]};
      ge          = rr >= {1'b0, cur.f.dmag};
      nx[k]       = cur;
      nx[k].rem   = ge ? 32'(rr - {1'b0, cur.f.dmag}) : rr[31:0];
      nx[k].f.nmag = {cur.f.nmag[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  assign out_valid            = v[N-1];
  assign out_item.temperature = st[N-1].f.temperature;
  assign out_item.humidity    = st[N-1].f.humidity;
  assign out_item.div_fault   = st[N-1].f.div_fault;
  assign out_item.post2       = st[N-1].f.post2;
  assign out_item.qneg        = st[N-1].f.qneg;
  assign out_item.quo         = st[N-1].f.nmag;

endmodule

// File: hw/rtl/ensc_back.sv
// Back pipeline: quotient sign fix and the quadratic and cubic pressure correction.
module ensc_back (
  input  logic                clk,
  input  logic                rst,
  input  ensc_pkg::ensc_cal_t cal,
  input  logic                in_valid,
  output logic                in_ready,
  input  ensc_pkg::ensc_quo_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ensc_pkg::ensc_out_t out_item
);
  import ensc_pkg::*;

  localparam int N = 5;

  typedef struct packed {
    logic [15:0]        temperature;
    logic [16:0]        humidity;
    logic               fault;
    logic signed [31:0] pc;
    logic signed [31:0] qq3;
    logic signed [31:0] v2;
    logic signed [31:0] q8;
    logic signed [31:0] qq8;
    logic signed [31:0] v1;
    logic signed [31:0] c3;
    logic signed [31:0] v3;
  } bk_t;

  logic signed [31:0] p7x128, p8, p9, p10;

  assign p7x128 = {{17{cal.press_cal_b[31]}}, cal.press_cal_b[31:24], 7'd0};
  assign p8     = {{16{cal.press_cal_b[47]}}, cal.press_cal_b[47:32]};
  assign p9     = {{16{cal.press_cal_b[63]}}, cal.press_cal_b[63:48]};
  assign p10    = {24'd0, cal.press_cal_c};

  bk_t          st [N];
  bk_t          nx [N];
  logic [N-1:0] v;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !v[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    logic signed [31:0] qs;
    logic signed [31:0] q3;
    nx[0] = '0;
    for (int k = 1; k < N; k++) begin
      nx[k] = st[k-1];
    end
    nx[0].temperature = in_item.temperature;
    nx[0].humidity    = in_item.humidity;
    nx[0].fault       = in_item.div_fault;
    qs                = in_item.qneg ? $signed(~in_item.quo + 32'd1) : $signed(in_item.quo);
    nx[0].pc          = in_item.post2 ? (qs <<< 1) : qs;
    q3                = st[0].pc >>> 3;
    nx[1].qq3         = q3 * q3;
    nx[1].v2          = ((st[0].pc >>> 2) * p8) >>> 13;
    nx[1].q8          = st[0].pc >>> 8;
    nx[1].qq8         = (st[0].pc >>> 8) * (st[0].pc >>> 8);
    nx[2].v1          = (p9 * (st[1].qq3 >>> 13)) >>> 12;
    nx[2].c3          = st[1].qq8 * st[1].q8;
    nx[3].v3          = (st[2].c3 * p10) >>> 17;
    if (st[3].fault) begin
      nx[4].pc = '0;
    end else begin
      nx[4].pc = st[3].pc + ((st[3].v1 + st[3].v2 + st[3].v3 + p7x128) >>> 4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  assign out_valid            = v[N-1];
  assign out_item.temperature = st[N-1].temperature;
  assign out_item.pressure    = st[N-1].pc;
  assign out_item.humidity    = st[N-1].humidity;
  assign out_item.div_fault   = st[N-1].fault;

endmodule

// File: hw/rtl/env_sensor_compensation_top.sv
// Top level of the environmental sensor compensation block.
// Takes one raw sample per cycle while in_ready is high and returns temperature,
// pressure and humidity, one result per item, in order. It is built from
// 14 front stages, 32 stages of the bit-per-stage pressure divider and 5 back stages.
// Every stage holds its item under backpressure, so empty stages keep taking items
// while a result waits. Calibration registers are written through cfg_we/cfg_index
// and are to be changed only while no item is in flight.
module env_sensor_compensation_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ensc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ensc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ensc_pkg::ensc_in_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ensc_pkg::ensc_out_t                 out_item
);
  import ensc_pkg::*;

  ensc_cal_t cal;
  ensc_fwd_t fwd_item;
  ensc_quo_t quo_item;
  logic      fwd_valid, fwd_ready, quo_valid, quo_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (ensc_reg_t'(cfg_index))
        REG_TEMP_CAL:    cal.temp_cal    <= cfg_data[39:0];
        REG_PRESS_CAL_A: cal.press_cal_a <= cfg_data[55:0];
        REG_PRESS_CAL_B: cal.press_cal_b <= cfg_data;
        REG_PRESS_CAL_C: cal.press_cal_c <= cfg_data[7:0];
        REG_HUM_CAL:     cal.hum_cal     <= cfg_data;
        default: ;
      endcase
    end
  end

  ensc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (fwd_valid),
    .out_ready (fwd_ready),
    .out_item  (fwd_item)
  );

  ensc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fwd_valid),
    .in_ready  (fwd_ready),
    .in_item   (fwd_item),
    .out_valid (quo_valid),
    .out_ready (quo_ready),
    .out_item  (quo_item)
  );

  ensc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (quo_valid),
    .in_ready  (quo_ready),
    .in_item   (quo_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: hw/rtl/ensc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
module ensc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ensc_pkg::ensc_out_t out_item
);
  import ensc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item shown right after reset");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.humidity <= HUM_MAX[16:0])
    else $error("humidity above clamp");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.div_fault |-> out_item.pressure == 32'sd0)
    else $error("pressure not zero on divide fault");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind env_sensor_compensation_top ensc_checker u_chk (.*);

// File: test/env_sensor_compensation_top_tb.sv
// Testbench for env_sensor_compensation_top: directed and random samples against a bit-exact predictor.
module env_sensor_compensation_top_tb;
  import ensc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 60;

  class comp_scoreboard;
    logic [39:0] temp_cal;
    logic [55:0] press_cal_a;
    logic [63:0] press_cal_b;
    logic [7:0]  press_cal_c;
    logic [63:0] hum_cal;
    ensc_out_t   pending_q[$];
    int          errors;
    int          n_checked;
    int          n_faults;

    function void clear_cal();
      temp_cal = '0; press_cal_a = '0; press_cal_b = '0; press_cal_c = '0; hum_cal = '0;
    endfunction

    function void set_cal(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_TEMP_CAL:    temp_cal = val[39:0];
        REG_PRESS_CAL_A: press_cal_a = val[55:0];
        REG_PRESS_CAL_B: press_cal_b = val;
        REG_PRESS_CAL_C: press_cal_c = val[7:0];
        REG_HUM_CAL:     hum_cal = val;
        default: ;
      endcase
    endfunction

    function longint w32(longint v);
      int t;
      t = v[31:0];
      return longint'(t);
    endfunction

    // compute compensated sample and queue it
    function void note_input(ensc_in_t s);
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
      longint h1, h2, h3, h4, h5, h6, h7;
      longint a, b, c, tf, ts, q, pc, e, v1, v2, v3, v4, v5, v6;
      ensc_out_t r;
      t1 = {48'd0, temp_cal[15:0]};     t2 = longint'($signed(temp_cal[31:16]));
      t3 = longint'($signed(temp_cal[39:32]));
      p1 = {48'd0, press_cal_a[15:0]};  p2 = longint'($signed(press_cal_a[31:16]));
      p3 = longint'($signed(press_cal_a[39:32])); p4 = longint'($signed(press_cal_a[55:40]));
      p5 = longint'($signed(press_cal_b[15:0]));  p6 = longint'($signed(press_cal_b[23:16]));
      p7 = longint'($signed(press_cal_b[31:24])); p8 = longint'($signed(press_cal_b[47:32]));
      p9 = longint'($signed(press_cal_b[63:48])); p10 = {56'd0, press_cal_c};
      h1 = {52'd0, hum_cal[11:0]};      h2 = {52'd0, hum_cal[23:12]};
      h3 = longint'($signed(hum_cal[31:24]));     h4 = longint'($signed(hum_cal[39:32]));
      h5 = longint'($signed(hum_cal[47:40]));     h6 = {56'd0, hum_cal[55:48]};
      h7 = longint'($signed(hum_cal[63:56]));

      a = {44'd0, s.temp_raw} >>> 3;
      a = a - t1 * 2;
      b = (a * t2) >>> 11;
      c = a >>> 1;
      c = (c * c) >>> 12;
      c = (c * (t3 * 16)) >>> 14;
      tf = w32(b + c);
      ts = w32(tf * 5 + 128) >>> 8;

      r.div_fault = 1'b0;
      v1 = w32((tf >>> 1) - 64000);
      q = v1 >>> 2;
      v2 = w32((w32(q * q) >>> 11) * p6) >>> 2;
      v2 = w32(v2 + w32(w32(v1 * p5) * 2));
      v2 = w32((v2 >>> 2) + w32(p4 * 65536));
      v1 = w32((w32((w32(q * q) >>> 13) * (p3 * 32)) >>> 3) + (w32(p2 * v1) >>> 1));
      v1 = v1 >>> 18;
      v1 = w32((32768 + v1) * p1) >>> 15;
      pc = 1048576 - longint'({44'd0, s.press_raw});
      pc = w32(w32(pc - (v2 >>> 12)) * 3125);
      if (v1 == 0) begin
        r.div_fault = 1'b1;
        pc = 0;
      end else begin
        if (pc >= 64'sh40000000) pc = w32(w32(pc / v1) * 2);
        else pc = w32(w32(pc * 2) / v1);
        q = pc >>> 3;
        v1 = w32(p9 * (w32(q * q) >>> 13)) >>> 12;
        v2 = w32((pc >>> 2) * p8) >>> 13;
        q = pc >>> 8;
        v3 = w32(w32(w32(q * q) * q) * p10) >>> 17;
        pc = w32(pc + (w32(v1 + v2 + v3 + p7 * 128) >>> 4));
      end

      a = w32(longint'({48'd0, s.hum_raw}) - h1 * 16);
      b = (w32(ts * h3) / 100) >>> 1;
      v1 = w32(a - b);
      a = w32(ts * h4) / 100;
      b = (w32(ts * (w32(ts * h5) / 100)) >>> 6) / 100;
      v2 = w32(h2 * w32(a + b + 16384)) >>> 10;
      v3 = w32(v1 * v2);
      v4 = w32(h6 * 128 + w32(ts * h7) / 100) >>> 4;
      e = v3 >>> 14;
      v5 = w32(e * e) >>> 10;
      v6 = w32(v4 * v5) >>> 1;
      e = w32((w32(v3 + v6) >>> 10) * 1000) >>> 12;
      if (e > 100000) e = 100000;
      else if (e < 0) e = 0;

      r.temperature = ts[15:0];
      r.pressure = pc[31:0];
      r.humidity = e[16:0];
      pending_q.push_back(r);
    endfunction

    function void check(ensc_out_t got);
      ensc_out_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      n_checked++;
      if (got.div_fault) n_faults++;
      if (got.temperature !== exp_r.temperature) begin
        $display("%0t: temperature exp %0d got %0d", $time, exp_r.temperature, got.temperature);
        errors++;
      end
      if (got.pressure !== exp_r.pressure) begin
        $display("%0t: pressure exp %0d got %0d", $time, exp_r.pressure, got.pressure);
        errors++;
      end
      if (got.humidity !== exp_r.humidity) begin
        $display("%0t: humidity exp %0d got %0d", $time, exp_r.humidity, got.humidity);
        errors++;
      end
      if (got.div_fault !== exp_r.div_fault) begin
        $display("%0t: div_fault exp %0b got %0b", $time, exp_r.div_fault, got.div_fault);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  ensc_in_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  ensc_out_t             out_item;

  comp_scoreboard sb;
  int max_gap;
  int n_sent;
  int n_cal_sets;

  env_sensor_compensation_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("** env_sensor_compensation_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_item);
    if (!rst && out_valid && out_ready) sb.check(out_item);
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, max_gap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_cal(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_cal(logic [39:0] tc, logic [55:0] pa, logic [63:0] pb,
                          logic [7:0] pcc, logic [63:0] hc);
    cfg_write(REG_TEMP_CAL, {24'd0, tc});
    cfg_write(REG_PRESS_CAL_A, {8'd0, pa});
    cfg_write(REG_PRESS_CAL_B, pb);
    cfg_write(REG_PRESS_CAL_C, {56'd0, pcc});
    cfg_write(REG_HUM_CAL, hc);
    n_cal_sets++;
  endtask

  task automatic send_sample(ensc_in_t s);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= s;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic directed_samples();
    send_sample('{20'd0, 20'd0, 16'd0});
    send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    send_sample('{20'hFFFFF, 20'd0, 16'd0});
    send_sample('{20'd0, 20'hFFFFF, 16'd0});
    send_sample('{20'd0, 20'd0, 16'hFFFF});
    send_sample('{20'd415148, 20'd519888, 16'd25000});
    send_sample('{20'd1, 20'd1, 16'd1});
    send_sample('{20'h80000, 20'h80000, 16'h8000});
  endtask

  // mostly realistic readings, some full-range noise
  task automatic random_samples(int count);
    ensc_in_t s;
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) begin
        s.press_raw = 20'($urandom_range(250000, 600000));
        s.temp_raw = 20'($urandom_range(380000, 620000));
        s.hum_raw = 16'($urandom_range(10000, 50000));
      end else begin
        s.press_raw = 20'($urandom);
        s.temp_raw = 20'($urandom);
        s.hum_raw = 16'($urandom);
      end
      send_sample(s);
    end
  endtask

  initial begin
    int phase;
    sb = new();
    sb.clear_cal();
    max_gap = 8;
    n_sent = 0;
    n_cal_sets = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration is all zero: divisor is zero
    directed_samples();
    random_samples(10);
    drain();

    load_cal(40'h03_6743_6B70, 56'h0B27_58_D641_8E7D, 64'h1770_F71C_001E_0078,
             8'h1E, 64'h9C78_142D_003E_82BC);
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, '1);
    directed_samples();
    random_samples(60);
    drain();
    max_gap = 0;
    random_samples(60);
    max_gap = 8;
    random_samples(40);
    drain();

    load_cal('1, '1, '1, '1, '1);
    directed_samples();
    random_samples(30);
    drain();

    load_cal(40'h7F_7FFF_0000, 56'h7FFF_7F_7FFF_FFFF, 64'h7FFF_7FFF_7F7F_7FFF,
             8'hFF, 64'h7FFF_7F7F_7FFF_F000);
    directed_samples();
    random_samples(30);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      load_cal(40'({$urandom, $urandom}), 56'({$urandom, $urandom}), {$urandom, $urandom},
               8'($urandom), {$urandom, $urandom});
      max_gap = (phase == 2) ? 0 : 8;
      random_samples(25);
      drain();
    end

    $display("Sent %0d samples over %0d calibration sets; %0d results checked, %0d with div fault.",
             n_sent, n_cal_sets, sb.n_checked, sb.n_faults);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** env_sensor_compensation_top: PASSED **");
    end else begin
      $display("** env_sensor_compensation_top: FAILED **");
    end
    $finish;
  end
endmodule
